[hw/rtl/cgba_pkg.sv]
package cgba_pkg;

  // grid geometry
  localparam int X_CELLS = 32;
  localparam int Y_CELLS = 32;
  localparam int R_CELLS = 8;
  localparam int DEPTH   = 8192;

  // field widths
  localparam int COORD_W = 16;
  localparam int FRAC_W  = 4;
  localparam int TOL_W   = 8;
  localparam int OCC_W   = 7;
  localparam int CNT_W   = 16;
  localparam int CELL_W  = $clog2(DEPTH);
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;

  // quotient of (v + half tol) / (16 tol) taken as ((v + half tol) >> 4) / tol
  localparam int DIV_W      = COORD_W - FRAC_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CELL_FULL_W = DIV_W + $clog2(X_CELLS * Y_CELLS) + 1;

  // stream payloads
  localparam int IN_FIELDS_W  = 3 * COORD_W + CELL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CELL_W + 1 + 3 * COORD_W + CNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_TOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_R    = 3'd5;

  localparam logic [TOL_W-1:0] PIXEL_TOL_RST  = 8'd30;
  localparam logic [TOL_W-1:0] RADIUS_TOL_RST = 8'd30;
  localparam logic [OCC_W-1:0] OCC_MIN_RST    = 7'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NEW     = 2'd0,
    ST_MERGED  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_MOD,
    S_OUT
  } fsm_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pos_t;

  // access to the cell store
  typedef struct packed {
    logic              rd_en;
    logic              wr_pos_en;
    logic              wr_cnt_en;
    logic [CELL_W-1:0] addr;
    pos_t              pos;
    logic [CNT_W-1:0]  cnt;
  } st_req_t;

  typedef struct packed {
    status_t            status;
    logic [CELL_W-1:0]  cell_out;
    logic               entry_valid;
    logic [COORD_W-1:0] avg_x;
    logic [COORD_W-1:0] avg_y;
    logic [COORD_W-1:0] avg_r;
    logic [CNT_W-1:0]   hit_count;
    logic               meets_min;
  } res_t;

endpackage

[hw/rtl/cgba_bin_div.sv]
module cgba_bin_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cgba_pkg::COORD_W-1:0]  value,
  input  logic [cgba_pkg::TOL_W-1:0]    tol,
  input  logic                          shift,
  output logic [cgba_pkg::DIV_W-1:0]    bin,
  output logic                          done
);
  import cgba_pkg::*;

  logic [TOL_W-1:0]     tol_eff;
  logic [COORD_W:0]     num;
  logic [DIV_W-1:0]     dividend;
  logic [TOL_W:0]       trial;
  logic                 ge;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [TOL_W-1:0]     rem_r, rem_nxt;
  logic [TOL_W-1:0]     div_r, div_nxt;

  // zero tolerance acts as one; the half shift adds tol * 8 in 12.4 units
  assign tol_eff  = (tol == '0) ? TOL_W'(1) : tol;
  assign num      = {1'b0, value} +
                    (shift ? (COORD_W+1)'({tol_eff, {(FRAC_W-1){1'b0}}}) : '0);
  assign dividend = num[COORD_W:FRAC_W];

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = tol_eff;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? TOL_W'(trial - {1'b0, div_r}) : trial[TOL_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign bin  = quo_r;
  assign done = done_r;

endmodule

[hw/rtl/cgba_store.sv]
module cgba_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cgba_pkg::st_req_t          req,
  output cgba_pkg::pos_t             rd_pos,
  output logic [cgba_pkg::CNT_W-1:0] rd_cnt,
  output logic                       init_done
);
  import cgba_pkg::*;

  pos_t             pos_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];

  pos_t             rd_pos_r;
  logic [CNT_W-1:0] rd_cnt_r;

  logic              clr_busy_r, clr_busy_nxt;
  logic [CELL_W-1:0] clr_addr_r, clr_addr_nxt;

  logic              cnt_we;
  logic [CELL_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;

  // count store is swept to zero after reset, one entry a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == CELL_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign cnt_we    = clr_busy_r | req.wr_cnt_en;
  assign cnt_waddr = clr_busy_r ? clr_addr_r : req.addr;
  assign cnt_wdata = clr_busy_r ? '0 : req.cnt;

  always_ff @(posedge clk) begin
    if (req.wr_pos_en) begin
      pos_mem[req.addr] <= req.pos;
    end
    if (req.rd_en) begin
      rd_pos_r <= pos_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (req.rd_en) begin
      rd_cnt_r <= cnt_mem[req.addr];
    end
  end

  assign rd_pos    = rd_pos_r;
  assign rd_cnt    = rd_cnt_r;
  assign init_done = !clr_busy_r;

`ifndef SYNTHESIS
  a_no_access_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(req.rd_en || req.wr_pos_en || req.wr_cnt_en))
    else $error("cell store accessed during clearing pass");
`endif

endmodule

[hw/rtl/circle_grid_bin_aggregator_top.sv]
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser: req_type; tdata: center_x, center_y, radius_in,
//         |     |                    |   cell_addr
// out_    | out | out_tvalid/tready  | tuser: status; tdata: cell_out, entry_valid, avg_x,
//         |     |                    |   avg_y, avg_r, hit_count, meets_min
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// Insert: the three 13-step bin dividers (one quotient bit a cycle, run side by side),
//   then the read-modify-write of the cell store; a circle that falls outside the grid
//   skips the store access.
// Read and clear: store read, update, result register.
// One request in flight; the next is taken while a finished result waits in out_.
// After reset all 8192 entries of the count store are cleared with in_tready low.
module circle_grid_bin_aggregator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] center_x, [31:16] center_y, [47:32] radius_in, [60:48] cell_addr
  input  logic [cgba_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [cgba_pkg::REQ_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [12:0] cell_out, [13] entry_valid, [29:14] avg_x, [45:30] avg_y, [61:46] avg_r,
  // [77:62] hit_count, [78] meets_min
  output logic [cgba_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [cgba_pkg::STAT_W-1:0]       out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [cgba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cgba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cgba_pkg::*;

  // config registers
  logic [TOL_W-1:0] pixel_tol_r, radius_tol_r;
  logic [OCC_W-1:0] occ_min_r;
  logic             shift_x_r, shift_y_r, shift_r_r;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r, out_res_nxt;
  res_t       res_r, res_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [CELL_W-1:0] addr_r, addr_nxt;
  pos_t              in_pos_r, in_pos_nxt;

  logic               accept;
  logic               div_start;
  logic [COORD_W-1:0] in_x, in_y, in_r;
  logic [CELL_W-1:0]  in_addr;
  logic [DIV_W-1:0]   bin_x, bin_y, bin_r;
  logic               done_x, done_y, done_r;
  logic [CELL_FULL_W-1:0] cell_full;
  logic               outside;

  st_req_t            st_req;
  pos_t               rd_pos;
  logic [CNT_W-1:0]   rd_cnt;
  logic               init_done;

  pos_t               new_pos;
  logic [CNT_W-1:0]   new_cnt;
  logic               cnt_zero;

  function automatic logic [COORD_W-1:0] avg2(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_W:1];
  endfunction

  assign in_x    = in_tdata[COORD_W-1:0];
  assign in_y    = in_tdata[2*COORD_W-1:COORD_W];
  assign in_r    = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_addr = in_tdata[3*COORD_W+CELL_W-1:3*COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_tol_r  <= PIXEL_TOL_RST;
      radius_tol_r <= RADIUS_TOL_RST;
      occ_min_r    <= OCC_MIN_RST;
      shift_x_r    <= 1'b0;
      shift_y_r    <= 1'b0;
      shift_r_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PIXEL_TOL:  pixel_tol_r  <= cfg_wdata[TOL_W-1:0];
        CFG_RADIUS_TOL: radius_tol_r <= cfg_wdata[TOL_W-1:0];
        CFG_OCC_MIN:    occ_min_r    <= cfg_wdata[OCC_W-1:0];
        CFG_SHIFT_X:    shift_x_r    <= cfg_wdata[0];
        CFG_SHIFT_Y:    shift_y_r    <= cfg_wdata[0];
        CFG_SHIFT_R:    shift_r_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE) && init_done;
  assign accept    = in_tvalid && in_tready;
  assign div_start = accept && (in_tuser == REQ_INSERT);

  cgba_bin_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (in_x),
    .tol   (pixel_tol_r),
    .shift (shift_x_r),
    .bin   (bin_x),
    .done  (done_x)
  );

  cgba_bin_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (in_y),
    .tol   (pixel_tol_r),
    .shift (shift_y_r),
    .bin   (bin_y),
    .done  (done_y)
  );

  cgba_bin_div u_div_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (in_r),
    .tol   (radius_tol_r),
    .shift (shift_r_r),
    .bin   (bin_r),
    .done  (done_r)
  );

  cgba_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (st_req),
    .rd_pos    (rd_pos),
    .rd_cnt    (rd_cnt),
    .init_done (init_done)
  );

  // cell = (rbin * Y_CELLS + ybin) * X_CELLS + xbin
  assign cell_full = CELL_FULL_W'(bin_r) * CELL_FULL_W'(X_CELLS * Y_CELLS) +
                     CELL_FULL_W'(bin_y) * CELL_FULL_W'(X_CELLS) +
                     CELL_FULL_W'(bin_x);
  assign outside   = (bin_x >= DIV_W'(X_CELLS)) || (bin_y >= DIV_W'(Y_CELLS)) ||
                     (bin_r >= DIV_W'(R_CELLS)) || (cell_full >= CELL_FULL_W'(DEPTH));

  assign cnt_zero = (rd_cnt == '0);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    in_pos_nxt    = in_pos_r;
    new_pos       = in_pos_r;
    new_cnt       = CNT_W'(1);
    st_req        = '0;
    st_req.addr   = addr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_tuser;
          addr_nxt   = in_addr;
          in_pos_nxt = '{r: in_r, y: in_y, x: in_x};
          case (in_tuser)
            REQ_INSERT:           state_nxt = S_DIV;
            REQ_READ, REQ_CLEAR:  state_nxt = S_RD;
            default:              state_nxt = S_IDLE;  // unused request code, dropped
          endcase
        end
      end
      S_DIV: begin
        if (done_x && done_y && done_r) begin
          if (outside) begin
            res_nxt        = '0;
            res_nxt.status = ST_OUTSIDE;
            state_nxt      = S_OUT;
          end else begin
            addr_nxt  = cell_full[CELL_W-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        st_req.rd_en = 1'b1;
        state_nxt    = S_MOD;
      end
      S_MOD: begin
        res_nxt.cell_out = addr_r;
        if (req_r == REQ_INSERT) begin
          if (cnt_zero) begin
            new_pos = in_pos_r;
            new_cnt = CNT_W'(1);
            res_nxt.status = ST_NEW;
          end else begin
            new_pos.x = avg2(rd_pos.x, in_pos_r.x);
            new_pos.y = avg2(rd_pos.y, in_pos_r.y);
            new_pos.r = avg2(rd_pos.r, in_pos_r.r);
            new_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
            res_nxt.status = ST_MERGED;
          end
          st_req.wr_pos_en    = 1'b1;
          st_req.wr_cnt_en    = 1'b1;
          st_req.pos          = new_pos;
          st_req.cnt          = new_cnt;
          res_nxt.entry_valid = 1'b1;
          res_nxt.avg_x       = new_pos.x;
          res_nxt.avg_y       = new_pos.y;
          res_nxt.avg_r       = new_pos.r;
          res_nxt.hit_count   = new_cnt;
          res_nxt.meets_min   = new_cnt >= CNT_W'(occ_min_r);
        end else begin
          // read or clear shows the entry as it stands before any clearing
          res_nxt.status      = ST_DONE;
          res_nxt.entry_valid = !cnt_zero;
          res_nxt.avg_x       = cnt_zero ? '0 : rd_pos.x;
          res_nxt.avg_y       = cnt_zero ? '0 : rd_pos.y;
          res_nxt.avg_r       = cnt_zero ? '0 : rd_pos.r;
          res_nxt.hit_count   = rd_cnt;
          res_nxt.meets_min   = !cnt_zero && (rd_cnt >= CNT_W'(occ_min_r));
          st_req.wr_cnt_en    = (req_r == REQ_CLEAR);
          st_req.cnt          = '0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    res_r     <= res_nxt;
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    in_pos_r  <= in_pos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       out_res_r.meets_min, out_res_r.hit_count,
                       out_res_r.avg_r, out_res_r.avg_y, out_res_r.avg_x,
                       out_res_r.entry_valid, out_res_r.cell_out};

`ifndef SYNTHESIS
  a_outside_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_OUTSIDE) |->
      (out_res_r.cell_out == '0 && !out_res_r.entry_valid && out_res_r.hit_count == '0))
    else $error("outside-grid result carries cell data");
`endif

`ifndef SYNTHESIS
  a_meets_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.meets_min) |->
      (out_res_r.entry_valid && out_res_r.hit_count != '0))
    else $error("meets_min set on an empty entry");
`endif

`ifndef SYNTHESIS
  a_request_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser == REQ_INSERT || in_tuser == REQ_READ || in_tuser == REQ_CLEAR))
      |=> (state_r != S_IDLE && !in_tready))
    else $error("accepted request did not start processing");
`endif

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cgba_pkg::*;

  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 12;
  localparam int MAX_PRINTED  = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  circle_grid_bin_aggregator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // grid model: settings, cell store and pending results
  logic [TOL_W-1:0] grid_pixel_tol;
  logic [TOL_W-1:0] grid_radius_tol;
  logic [OCC_W-1:0] grid_occ_min;
  logic grid_shift_x, grid_shift_y, grid_shift_r;
  logic [CNT_W-1:0] hits_per_cell [DEPTH];
  pos_t cell_pos [DEPTH];
  logic [CELL_W-1:0] touched_cells [$];
  res_t expected_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int result_count = 0;
  int unsigned cycle_count = 0;
  res_t want;

  function automatic int unsigned grid_bin(input logic [COORD_W-1:0] v,
                                           input logic [TOL_W-1:0] tol, input logic half);
    int unsigned t;
    t = (tol == 0) ? 1 : tol;
    return (v + (half ? t * 8 : 0)) / (t * 16);
  endfunction

  function automatic res_t cell_view(input status_t st, input int unsigned cell_idx);
    res_t v;
    logic [CNT_W-1:0] hits;
    hits = hits_per_cell[cell_idx];
    v = '0;
    v.status = st;
    v.cell_out = cell_idx[CELL_W-1:0];
    v.hit_count = hits;
    if (hits != 0) begin
      v.entry_valid = 1'b1;
      v.avg_x = cell_pos[cell_idx].x;
      v.avg_y = cell_pos[cell_idx].y;
      v.avg_r = cell_pos[cell_idx].r;
      v.meets_min = (hits >= grid_occ_min);
    end
    return v;
  endfunction

  task automatic predict_request(input logic [REQ_W-1:0] req,
                                 input logic [COORD_W-1:0] x, y, r,
                                 input logic [CELL_W-1:0] addr);
    int unsigned xb, yb, rb, cell_idx;
    logic [COORD_W:0] sum_x, sum_y, sum_r;
    res_t v;
    if (req == REQ_INSERT) begin
      xb = grid_bin(x, grid_pixel_tol, grid_shift_x);
      yb = grid_bin(y, grid_pixel_tol, grid_shift_y);
      rb = grid_bin(r, grid_radius_tol, grid_shift_r);
      cell_idx = (rb * Y_CELLS + yb) * X_CELLS + xb;
      if (xb >= X_CELLS || yb >= Y_CELLS || rb >= R_CELLS || cell_idx >= DEPTH) begin
        v = '0;
        v.status = ST_OUTSIDE;
      end else if (hits_per_cell[cell_idx] == 0) begin
        cell_pos[cell_idx] = '{r: r, y: y, x: x};
        hits_per_cell[cell_idx] = CNT_W'(1);
        touched_cells = {touched_cells, cell_idx[CELL_W-1:0]};
        if (touched_cells.size() > 64) void'(touched_cells.pop_front());
        v = cell_view(ST_NEW, cell_idx);
      end else begin
        // average of old and new, half LSB dropped
        sum_x = {1'b0, cell_pos[cell_idx].x} + {1'b0, x};
        sum_y = {1'b0, cell_pos[cell_idx].y} + {1'b0, y};
        sum_r = {1'b0, cell_pos[cell_idx].r} + {1'b0, r};
        cell_pos[cell_idx] = '{r: sum_r[COORD_W:1], y: sum_y[COORD_W:1], x: sum_x[COORD_W:1]};
        if (hits_per_cell[cell_idx] != '1)
          hits_per_cell[cell_idx] = hits_per_cell[cell_idx] + 1'b1;
        v = cell_view(ST_MERGED, cell_idx);
      end
      expected_results = {expected_results, v};
    end else if (req == REQ_READ) begin
      expected_results = {expected_results, cell_view(ST_DONE, 32'(addr))};
    end else if (req == REQ_CLEAR) begin
      expected_results = {expected_results, cell_view(ST_DONE, 32'(addr))};
      hits_per_cell[addr] = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("[%0t] result %0d: %s", $realtime, result_count, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp_val);
    if (got !== exp_val) report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = expected_results.pop_front();
        check_field("status", out_tuser, want.status);
        check_field("cell_out", out_tdata[12:0], want.cell_out);
        check_field("entry_valid", out_tdata[13], want.entry_valid);
        check_field("avg_x", out_tdata[29:14], want.avg_x);
        check_field("avg_y", out_tdata[45:30], want.avg_y);
        check_field("avg_r", out_tdata[61:46], want.avg_r);
        check_field("hit_count", out_tdata[77:62], want.hit_count);
        check_field("meets_min", out_tdata[78], want.meets_min);
      end
      result_count++;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x, y, r,
                              input logic [CELL_W-1:0] addr);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {3'b000, addr, r, y, x};
    do @(posedge clk); while (!in_tready);
    predict_request(req, x, y, r, addr);
  endtask

  // also covers a trailing ignored request, which the DUT drops without a result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [TOL_W-1:0] ptol, rtol, input logic [OCC_W-1:0] occ,
                               input logic sx, sy, sr);
    logic [CFG_IDX_W-1:0] idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_PIXEL_TOL, CFG_RADIUS_TOL, CFG_OCC_MIN, CFG_SHIFT_X, CFG_SHIFT_Y, CFG_SHIFT_R};
    val = '{ptol, rtol, {1'b0, occ}, {7'd0, sx}, {7'd0, sy}, {7'd0, sr}};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    grid_pixel_tol = ptol;
    grid_radius_tol = rtol;
    grid_occ_min = occ;
    grid_shift_x = sx;
    grid_shift_y = sy;
    grid_shift_r = sr;
  endtask

  function automatic int unsigned coord_span(input logic [TOL_W-1:0] tol, input int cells);
    int unsigned t, s;
    t = (tol == 0) ? 1 : tol;
    s = t * 16 * cells - 1;
    return (s > 65535) ? 65535 : s;
  endfunction

  function automatic logic [COORD_W-1:0] jittered(input logic [COORD_W-1:0] base);
    int unsigned s;
    s = base + $urandom_range(31);
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(REQ_INSERT, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_INSERT, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_INSERT, 16'd15, 16'd15, 16'd15, 13'd0);
    send_request(REQ_INSERT, 16'd479, 16'd479, 16'd479, 13'd0);
    send_request(REQ_INSERT, 16'd480, 16'd0, 16'd0, 13'h1FFF);
    // top corner of the grid, then one step past each edge
    send_request(REQ_INSERT, 16'd15359, 16'd15359, 16'd3839, 13'd0);
    send_request(REQ_INSERT, 16'd15360, 16'd0, 16'd0, 13'd0);
    send_request(REQ_INSERT, 16'd0, 16'd15360, 16'd0, 13'd0);
    send_request(REQ_INSERT, 16'd0, 16'd0, 16'd3840, 13'd0);
    send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF);
    send_request(REQ_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'h1FFF);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'd100);
    send_request(REQ_IGNORED, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 13'd0);
    send_request(REQ_INSERT, 16'd1, 16'd1, 16'd1, 13'd0);
    send_request(REQ_INSERT, 16'd2, 16'd2, 16'd2, 13'd0);
    // bring the corner cell up to the default threshold
    repeat (9) send_request(REQ_INSERT, 16'd15359, 16'd15359, 16'd3839, 13'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'h1FFF);
  endtask

  task automatic test_setting_extremes();
    wait_idle();
    load_settings(8'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_INSERT, 16'd83, 16'd16, 16'd31, 13'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'd1061);
    send_request(REQ_INSERT, 16'd512, 16'd0, 16'd0, 13'd0);
    wait_idle();
    load_settings(8'd150, 8'd150, 7'd100, 1'b1, 1'b1, 1'b1);
    send_request(REQ_INSERT, 16'hFFFF, 16'd0, 16'd15599, 13'd0);
    send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'd15600, 13'd0);
    send_request(REQ_INSERT, 16'd0, 16'd0, 16'hFFFF, 13'd0);
    wait_idle();
    load_settings(8'd1, 8'd1, 7'd1, 1'b1, 1'b0, 1'b1);
    send_request(REQ_INSERT, 16'd7, 16'd7, 16'd7, 13'd0);
    send_request(REQ_INSERT, 16'd8, 16'd8, 16'd8, 13'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 13'd0);
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int unsigned span_xy, span_r, pick, k;
    int sent;
    logic [COORD_W-1:0] base_x [POOL_SIZE];
    logic [COORD_W-1:0] base_y [POOL_SIZE];
    logic [COORD_W-1:0] base_r [POOL_SIZE];
    logic [COORD_W-1:0] x, y, r;
    logic [CELL_W-1:0] addr;
    logic [REQ_W-1:0] req;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    span_xy = coord_span(grid_pixel_tol, X_CELLS);
    span_r = coord_span(grid_radius_tol, R_CELLS);
    for (int i = 0; i < POOL_SIZE; i++) begin
      base_x[i] = COORD_W'($urandom_range(span_xy));
      base_y[i] = COORD_W'($urandom_range(span_xy));
      base_r[i] = COORD_W'($urandom_range(span_r));
    end
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      x = COORD_W'($urandom_range(16'hFFFF));
      y = COORD_W'($urandom_range(16'hFFFF));
      r = COORD_W'($urandom_range(16'hFFFF));
      addr = CELL_W'($urandom_range(13'h1FFF));
      if (pick < 55) begin
        // clustered detections so cells merge and counts climb
        req = REQ_INSERT;
        k = $urandom_range(POOL_SIZE - 1);
        x = jittered(base_x[k]);
        y = jittered(base_y[k]);
        r = jittered(base_r[k]);
      end else if (pick < 65) begin
        req = REQ_INSERT;
      end else if (pick < 95) begin
        req = (pick < 82) ? REQ_READ : REQ_CLEAR;
        if (touched_cells.size() != 0 && $urandom_range(3) != 0)
          addr = touched_cells[$urandom_range(touched_cells.size() - 1)];
      end else begin
        req = REQ_IGNORED;
      end
      send_request(req, x, y, r, addr);
      if (req != REQ_IGNORED) sent++;
    end
  endtask

  task automatic test_random_traffic();
    wait_idle();
    load_settings(8'd150, 8'd150, 7'd100, 1'b1, 1'b1, 1'b1);
    run_random_phase(200, 0, 0);
    wait_idle();
    load_settings(8'd1, 8'd1, 7'd1, 1'b0, 1'b0, 1'b0);
    run_random_phase(200, 81, 0);
    wait_idle();
    load_settings(TOL_W'($urandom_range(1, 150)), TOL_W'($urandom_range(1, 150)),
                  OCC_W'($urandom_range(1, 100)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    run_random_phase(200, 0, 81);
    wait_idle();
    load_settings(TOL_W'($urandom_range(1, 150)), TOL_W'($urandom_range(1, 150)),
                  OCC_W'($urandom_range(1, 12)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    run_random_phase(200, 28, 28);
  endtask

  initial begin
    grid_pixel_tol = PIXEL_TOL_RST;
    grid_radius_tol = RADIUS_TOL_RST;
    grid_occ_min = OCC_MIN_RST;
    grid_shift_x = 1'b0;
    grid_shift_y = 1'b0;
    grid_shift_r = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      hits_per_cell[i] = '0;
      cell_pos[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_setting_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
